### rtl/trc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_pkg: shared types and constants
// Item and result structures, opcodes and sizes of the 16-bit core.
// ----------------------------------------------------------------------------
package trc_pkg;

	localparam int MEM_WORDS_DEF = 4096;
	localparam int REG_COUNT_DEF = 8;

	// Item kinds.
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_RESTART = 2'd1;
	localparam logic [1:0] FUNC_EXEC    = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_RUN    = 2'd0;
	localparam logic [1:0] ST_HALT   = 2'd1;
	localparam logic [1:0] ST_DIVZ   = 2'd2;

	// Opcodes.
	localparam logic [3:0] OP_REG   = 4'h0;
	localparam logic [3:0] OP_BEQ   = 4'h1;
	localparam logic [3:0] OP_BGT   = 4'h2;
	localparam logic [3:0] OP_JMP   = 4'h3;
	localparam logic [3:0] OP_LOAD  = 4'h4;
	localparam logic [3:0] OP_STORE = 4'h5;
	localparam logic [3:0] OP_ADDI  = 4'hA;
	localparam logic [3:0] OP_SUBI  = 4'hB;
	localparam logic [3:0] OP_HALT  = 4'hF;

	// Register functions.
	localparam logic [2:0] FN_AND = 3'd0;
	localparam logic [2:0] FN_OR  = 3'd1;
	localparam logic [2:0] FN_ADD = 3'd2;
	localparam logic [2:0] FN_SUB = 3'd3;
	localparam logic [2:0] FN_MUL = 3'd4;
	localparam logic [2:0] FN_DIV = 3'd5;

	localparam logic [15:0] HALT_WORD = 16'hF000;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] load_address;
		logic [15:0] load_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] next_pc;
		logic [15:0] executed_word;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        mem_written;
		logic [15:0] mem_address;
		logic [15:0] mem_value;
	} out_item_t;

	// Divider handshake.
	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
	} div_rsp_t;

endpackage

### rtl/tiny_16bit_risc_core_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_16bit_risc_core_unit: 16-bit multicycle processor
// Each input transfer loads a memory word, restarts at the start address, or
// executes one instruction. One result transfer follows each item.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready move one item (func, load_address, load_data).
//   out_valid/out_ready move one result with status, pc and write reports.
//   cfg_valid/cfg_ready write the start address; it takes effect on the
//   next restart.
// An executed instruction passes through fetch, decode, execute and
// writeback; multiply and load pass through an extra state before
// writeback, and divide waits for the divider (one quotient bit a cycle).
// Load, restart and idle items go straight to writeback.
// The synchronous word memory read port sets the fetch and load steps.
// Items are handled one at a time: the next item is taken the cycle after a
// result enters the output register, so no item starts before the last
// one's result has left the core. While the receiver stalls, the next item
// still runs; its result then waits in the core and no further item is
// taken until the output register is free.
// Reset clears registers, pc, status; the memory holds no reset value.
// ----------------------------------------------------------------------------
module tiny_16bit_risc_core_unit #(
	parameter int MEM_WORDS = trc_pkg::MEM_WORDS_DEF,
	parameter int REG_COUNT = trc_pkg::REG_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  trc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output trc_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	logic               idle;
	logic               pend_q;
	logic               load_out;
	logic [15:0]        start_q;
	trc_pkg::out_item_t res;

	// One item in the core at a time; its result moves out when the slot frees.
	assign in_ready  = idle && !pend_q;
	assign load_out  = pend_q && idle && (!out_valid || out_ready);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid) begin
			start_q <= cfg_data;
		end
	end

	trc_core #(
		.MEM_WORDS (MEM_WORDS),
		.REG_COUNT (REG_COUNT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.boot_pc    (start_q),
		.go         (in_valid && in_ready),
		.item       (in_data),
		.res        (res),
		.idle       (idle)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				pend_q <= 1'b1;
			end else if (load_out) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data <= res;
		end
	end

endmodule

### rtl/trc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_div: signed restoring divider
// Truncating 16-bit signed division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  trc_pkg::div_req_t req,
	output trc_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] dvs_q;
	logic        neg_q;
	logic        done_q;
	logic [16:0] trial;
	logic [15:0] abs_a;
	logic [15:0] abs_b;

	assign abs_a = req.dividend[15] ? (16'd0 - req.dividend) : req.dividend;
	assign abs_b = req.divisor[15] ? (16'd0 - req.divisor) : req.divisor;
	assign trial = {rem_q, quo_q[15]} - {1'b0, dvs_q};

	// Shift and subtract iteration on magnitudes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= abs_a;
			dvs_q <= abs_b;
			neg_q <= req.dividend[15] ^ req.divisor[15];
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (16'd0 - quo_q) : quo_q;

endmodule

### rtl/trc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_core: multicycle sequencer
// Fetches from the word memory, reads the register file, executes and
// writes back. Memory has a synchronous read port; the register file is read combinationally and written synchronously.
// ----------------------------------------------------------------------------
module trc_core #(
	parameter int MEM_WORDS = trc_pkg::MEM_WORDS_DEF,
	parameter int REG_COUNT = trc_pkg::REG_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         boot_pc,
	input  logic                go,
	input  trc_pkg::in_item_t   item,
	output trc_pkg::out_item_t  res,
	output logic                idle
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int RW = $clog2(REG_COUNT);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_LDW   = 3'd6;
	localparam logic [2:0] S_WB    = 3'd7;

	logic [15:0] mem [MEM_WORDS];
	logic [15:0] rf  [REG_COUNT];

	logic [2:0]  state_q;
	logic [15:0] pc_q;
	logic [1:0]  stop_q;
	logic [15:0] word_q;
	logic [15:0] a_q, b_q;
	logic [15:0] rdata_q;
	logic [31:0] prod_q;
	logic        rw_q, mw_q;
	logic [2:0]  ridx_q;
	logic [15:0] rval_q;
	logic [15:0] maddr_q, mval_q;

	// Memory port controls.
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0]   mem_wd;
	logic [AW-1:0] mem_ra;
	logic          rf_we;

	trc_pkg::div_req_t dreq;
	trc_pkg::div_rsp_t drsp;

	logic [3:0]  op;
	logic [2:0]  rs, rt, rd, fn;
	logic [15:0] imm, off, nxt, ea;
	logic [15:0] pc_exec;
	logic [2:0]  state_exec;

	assign op  = word_q[15:12];
	assign rs  = word_q[11:9];
	assign rt  = word_q[8:6];
	assign rd  = word_q[5:3];
	assign fn  = word_q[2:0];
	assign imm = {{10{word_q[5]}}, word_q[5:0]};
	assign off = {{4{word_q[11]}}, word_q[11:0]};
	assign nxt = pc_q + 16'd2;
	assign ea  = a_q + {imm[14:0], 1'b0};

	trc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign dreq.start    = (state_q == S_EXEC) && (op == trc_pkg::OP_REG)
		&& (fn == trc_pkg::FN_DIV) && (b_q != 16'd0);
	assign dreq.dividend = a_q;
	assign dreq.divisor  = b_q;

	// Next pc and next state of the execute step.
	always_comb begin
		pc_exec    = nxt;
		state_exec = S_WB;
		case (op)
			trc_pkg::OP_REG: begin
				if (fn == trc_pkg::FN_MUL) begin
					state_exec = S_MUL;
				end
				if (fn == trc_pkg::FN_DIV && b_q != 16'd0) begin
					state_exec = S_DIV;
				end
			end
			trc_pkg::OP_LOAD: state_exec = S_LDW;
			trc_pkg::OP_BEQ: begin
				if (a_q == b_q) pc_exec = nxt + {imm[14:0], 1'b0};
			end
			trc_pkg::OP_BGT: begin
				if (a_q > b_q) pc_exec = nxt + {imm[14:0], 1'b0};
			end
			trc_pkg::OP_JMP: pc_exec = nxt + {off[14:0], 1'b0};
			default: ;
		endcase
	end

	// Memory address muxing.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = item.load_address[AW:1];
		mem_wd = item.load_data;
		mem_ra = pc_q[AW:1];
		if (state_q == S_IDLE && go && item.func == trc_pkg::FUNC_LOAD) begin
			mem_we = 1'b1;
		end
		if (state_q == S_EXEC) begin
			mem_ra = ea[AW:1];
			if (op == trc_pkg::OP_STORE) begin
				mem_we = 1'b1;
				mem_wa = ea[AW:1];
				mem_wd = b_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	// Register file: one write at writeback.
	assign rf_we = (state_q == S_WB) && rw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				rf[i] <= '0;
			end
		end else if (rf_we) begin
			rf[ridx_q[RW-1:0]] <= rval_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= $signed(a_q) * $signed(b_q);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			stop_q  <= trc_pkg::ST_RUN;
			word_q  <= '0;
			rw_q    <= 1'b0;
			mw_q    <= 1'b0;
			ridx_q  <= '0;
			rval_q  <= '0;
			maddr_q <= '0;
			mval_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (go) begin
						word_q <= '0;
						rw_q   <= 1'b0;
						mw_q   <= 1'b0;
						ridx_q <= '0;
						rval_q <= '0;
						maddr_q <= '0;
						mval_q  <= '0;
						if (item.func == trc_pkg::FUNC_RESTART) begin
							pc_q   <= boot_pc;
							stop_q <= trc_pkg::ST_RUN;
						end
						if (item.func == trc_pkg::FUNC_EXEC && stop_q == trc_pkg::ST_RUN) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_WB;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					word_q  <= rdata_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (word_q == trc_pkg::HALT_WORD) begin
						stop_q  <= trc_pkg::ST_HALT;
						state_q <= S_WB;
					end else begin
						pc_q    <= pc_exec;
						state_q <= state_exec;
						case (op)
							trc_pkg::OP_REG: begin
								if (fn <= trc_pkg::FN_DIV
									&& !(fn == trc_pkg::FN_DIV && b_q == 16'd0)) begin
									rw_q   <= 1'b1;
									ridx_q <= rd;
								end
								case (fn)
									trc_pkg::FN_AND: rval_q <= a_q & b_q;
									trc_pkg::FN_OR:  rval_q <= a_q | b_q;
									trc_pkg::FN_ADD: rval_q <= a_q + b_q;
									trc_pkg::FN_SUB: rval_q <= a_q - b_q;
									trc_pkg::FN_DIV: begin
										if (b_q == 16'd0) begin
											stop_q <= trc_pkg::ST_DIVZ;
										end
									end
									default: ;
								endcase
							end
							trc_pkg::OP_ADDI: begin
								rw_q <= 1'b1; ridx_q <= rt; rval_q <= a_q + imm;
							end
							trc_pkg::OP_SUBI: begin
								rw_q <= 1'b1; ridx_q <= rt; rval_q <= a_q - imm;
							end
							trc_pkg::OP_LOAD: begin
								rw_q <= 1'b1; ridx_q <= rt;
							end
							trc_pkg::OP_STORE: begin
								mw_q <= 1'b1; maddr_q <= ea; mval_q <= b_q;
							end
							trc_pkg::OP_HALT: stop_q <= trc_pkg::ST_HALT;
							default: ;
						endcase
					end
				end
				S_MUL: begin
					rval_q  <= prod_q[15:0];
					state_q <= S_WB;
				end
				S_DIV: begin
					if (drsp.done) begin
						rval_q  <= drsp.quotient;
						state_q <= S_WB;
					end
				end
				S_LDW: begin
					rval_q  <= rdata_q;
					state_q <= S_WB;
				end
				S_WB: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operands are read from the register file in the decode state and registered alongside the instruction word.
	always_ff @(posedge clk) begin
		if (state_q == S_DEC) begin
			a_q <= rf[rdata_q[11:9]];
			b_q <= rf[rdata_q[8:6]];
		end
	end

	assign idle = (state_q == S_IDLE);

	assign res.status        = stop_q;
	assign res.next_pc       = pc_q;
	assign res.executed_word = word_q;
	assign res.reg_written   = rw_q;
	assign res.reg_index     = rw_q ? ridx_q : 3'd0;
	assign res.reg_value     = rw_q ? rval_q : 16'd0;
	assign res.mem_written   = mw_q;
	assign res.mem_address   = maddr_q;
	assign res.mem_value     = mval_q;

endmodule

### rtl/trc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_checker: port-level properties
// Watches the top-level ports for ordering and status behavior.
// ----------------------------------------------------------------------------
module trc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input trc_pkg::out_item_t out_data
);

	// A held result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// No input transfer right after another: each item needs a result first.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken before result");

	// Status code stays in its legal range.
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == trc_pkg::ST_RUN
			|| out_data.status == trc_pkg::ST_HALT
			|| out_data.status == trc_pkg::ST_DIVZ))
		else $error("illegal status");

	// Register value is zero when no register was written.
	a_rz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.reg_written |-> out_data.reg_value == 16'd0)
		else $error("stray register value");

endmodule

bind tiny_16bit_risc_core_unit trc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
